/* sv/spq_pkg.sv */
// Shared types, constants and codes for the stable priority queue.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [15:0] item_data;
    logic [7:0]  item_priority;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] head_data;
    logic        head_valid;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } out_beat_t;

  typedef enum logic {
    CS_IDLE,
    CS_HOLD
  } ctl_state_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       load;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

/* sv/stable_priority_queue.sv */
// Top level of the stable priority queue: controller and slot datapath.
//
//   Channel  Ports                       Beat contents
//   input    in_valid  in_stall  in_data     mode, item_data, item_priority
//   result   out_valid out_stall out_data    head_data, head_valid, entry_count, status
//
// For each accepted beat every slot compares its priority with the new one in parallel
// and the row shifts by one place, so a beat can be taken every cycle unless the input
// stalls. Its result sits in the output register from the next cycle. The input stalls
// only while a result waits there and the result side stalls; a new beat may enter in
// the cycle the waiting result leaves. Reset empties the queue and clears the result
// valid flag; slots above the count are never read.
module stable_priority_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output spq_pkg::out_beat_t out_data
);
  import spq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller decides whether a beat is taken and which operation the
  // datapath performs; a full insert or an empty remove only reports status.
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the sorted slots, the count and the result register.
  spq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

/* sv/spq_dp.sv */
// Datapath: sorted slot row, entry count and result register.
module spq_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::in_beat_t  in_data,
  input  spq_pkg::dp_cmd_t   cmd,
  output spq_pkg::dp_stat_t  stat,
  output spq_pkg::out_beat_t out_data
);
  import spq_pkg::*;

  logic [15:0]      slot_data_r [CAPACITY];
  logic [7:0]       slot_prio_r [CAPACITY];
  logic [15:0]      slot_data_nxt [CAPACITY];
  logic [7:0]       slot_prio_nxt [CAPACITY];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CAPACITY-1:0] le;
  out_beat_t        out_r;

  // Each held slot whose priority is at or below the new one stays put; the
  // sorted order makes this mask a prefix, so its edge is the insert point.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      le[k] = (CNT_W'(k) < cnt_r) && (slot_prio_r[k] <= in_data.item_priority);
    end
  end

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      slot_data_nxt[k] = slot_data_r[k];
      slot_prio_nxt[k] = slot_prio_r[k];
      if (cmd.push && !le[k]) begin
        if (k == 0 || le[(k == 0) ? 0 : k - 1]) begin
          slot_data_nxt[k] = in_data.item_data;
          slot_prio_nxt[k] = in_data.item_priority;
        end else begin
          slot_data_nxt[k] = slot_data_r[(k == 0) ? 0 : k - 1];
          slot_prio_nxt[k] = slot_prio_r[(k == 0) ? 0 : k - 1];
        end
      end else if (cmd.pop && k < CAPACITY - 1) begin
        slot_data_nxt[k] = slot_data_r[(k < CAPACITY - 1) ? k + 1 : k];
        slot_prio_nxt[k] = slot_prio_r[(k < CAPACITY - 1) ? k + 1 : k];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CAPACITY; k++) begin
      slot_data_r[k] <= slot_data_nxt[k];
      slot_prio_r[k] <= slot_prio_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r.head_valid  <= (cnt_nxt != '0);
      out_r.head_data   <= (cnt_nxt != '0) ? slot_data_nxt[0] : 16'd0;
      out_r.entry_count <= 5'(cnt_nxt);
      out_r.status      <= cmd.status;
    end
  end

  assign stat.full  = (cnt_r == CNT_W'(CAPACITY));
  assign stat.empty = (cnt_r == '0);
  assign out_data   = out_r;

endmodule

/* sv/spq_ctrl.sv */
// Controller: result register occupancy, input acceptance and command decode.
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  spq_pkg::dp_stat_t stat,
  output spq_pkg::dp_cmd_t  cmd
);
  import spq_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;
  logic       accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    in_stall   = (state_r == CS_HOLD) && out_stall;
    out_valid  = (state_r == CS_HOLD);
    accept     = in_valid && !in_stall;
    cmd        = '0;
    cmd.load   = accept;
    cmd.status = ST_OK;
    if (accept) begin
      if (in_mode == MODE_INSERT) begin
        if (stat.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.push = 1'b1;
        end
      end else begin
        if (stat.empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.pop = 1'b1;
        end
      end
    end
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (accept) begin
          state_nxt = CS_HOLD;
        end
      end
      CS_HOLD: begin
        if (!accept && !out_stall) begin
          state_nxt = CS_IDLE;
        end
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

endmodule
